@@ sv/point_in_polygon_test_defines.svh @@
// ----------------------------------------------------------------------------
// Point in polygon test: assertion macros
// Shared concurrent assertion forms used by the modules of the block.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_TEST_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("point_in_polygon_test: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PIP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("point_in_polygon_test: next-cycle check failed");

`endif

@@ sv/pip_pkg.sv @@
// ----------------------------------------------------------------------------
// Point in polygon test: package
// Widths, defaults, edge and location codes, and the job control record.
// ----------------------------------------------------------------------------
package pip_pkg;

    // Fixed widths of the payload ports.
    localparam int FIELD_WIDTH = 32;
    localparam int LOC_WIDTH   = 2;

    // Defaults for the top-level parameters.
    localparam int COORD_WIDTH_DEF = 32;
    localparam int JOB_DEPTH_DEF   = 4;
    localparam int RES_DEPTH_DEF   = 2;

    // Vertex count saturates here; three vertices make a real polygon.
    localparam logic [1:0] COUNT_SAT = 2'd3;

    // Outcome of testing one edge against the query point.
    typedef enum logic [1:0] {
        EDGE_NONE     = 2'd0,
        EDGE_TOGGLE   = 2'd1,
        EDGE_BOUNDARY = 2'd2
    } t_edge_res;

    // Classification reported for a polygon.
    typedef enum logic [1:0] {
        LOC_OUTSIDE  = 2'd0,
        LOC_INSIDE   = 2'd1,
        LOC_BOUNDARY = 2'd2
    } t_location;

    // Control part of a job passed from the front end to the back end.
    typedef struct packed {
        logic last;        // closes the polygon, a result follows
        logic short_poly;  // fewer than three vertices in the polygon
        logic edge_a;      // edge from the previous vertex is tested
        logic edge_b;      // closing edge back to the first vertex is tested
    } t_job_ctl;

    localparam int CTL_WIDTH = $bits(t_job_ctl);

endpackage

@@ sv/point_in_polygon_test.sv @@
// ----------------------------------------------------------------------------
// Point in polygon test: top level
// Crossing-parity classification of a query point against a closed polygon
// that arrives one vertex per item, with exact 66-bit cross products by default.
//
//   Channel   Direction  Handshake           Payload
//   vertices  in         push / full         i_query_x/y, i_vertex_x/y, i_last_vertex
//   results   out        empty / pop         o_location (0 out, 1 in, 2 boundary)
//
// One vertex is taken every cycle while the job queue has room; the edge
// units are two-stage pipelines that sustain that rate.
// A result passes the job queue, both edge unit stages and the result queue.
// Reset is synchronous and active low; it clears the queues and all
// per-polygon state, and no clearing pass follows.
// A full result queue holds the back end, the job queue then fills and
// raises full; either side may stall at any time without loss.
// ----------------------------------------------------------------------------
module point_in_polygon_test #(
    parameter int COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF,
    parameter int JOB_DEPTH   = pip_pkg::JOB_DEPTH_DEF,
    parameter int RES_DEPTH   = pip_pkg::RES_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [pip_pkg::FIELD_WIDTH-1:0]   i_query_x,
    input  logic [pip_pkg::FIELD_WIDTH-1:0]   i_query_y,
    input  logic [pip_pkg::FIELD_WIDTH-1:0]   i_vertex_x,
    input  logic [pip_pkg::FIELD_WIDTH-1:0]   i_vertex_y,
    input  logic                              i_last_vertex,
    output logic                              empty,
    input  logic                              pop,
    output logic [pip_pkg::LOC_WIDTH-1:0]     o_location
);

    localparam int JW = 8 * COORD_WIDTH + pip_pkg::CTL_WIDTH;

    logic                          w_job_push;
    logic                          w_job_full;
    logic                          w_job_pop;
    logic                          w_job_empty;
    logic [JW-1:0]                 w_job_in;
    logic [JW-1:0]                 w_job_out;
    logic [COORD_WIDTH-1:0]        w_prev_x;
    logic [COORD_WIDTH-1:0]        w_prev_y;
    logic [COORD_WIDTH-1:0]        w_first_x;
    logic [COORD_WIDTH-1:0]        w_first_y;
    pip_pkg::t_job_ctl             w_ctl;
    pip_pkg::t_job_ctl             w_hd_ctl;
    logic [COORD_WIDTH-1:0]        w_hd_px;
    logic [COORD_WIDTH-1:0]        w_hd_py;
    logic [COORD_WIDTH-1:0]        w_hd_prev_x;
    logic [COORD_WIDTH-1:0]        w_hd_prev_y;
    logic [COORD_WIDTH-1:0]        w_hd_vx;
    logic [COORD_WIDTH-1:0]        w_hd_vy;
    logic [COORD_WIDTH-1:0]        w_hd_first_x;
    logic [COORD_WIDTH-1:0]        w_hd_first_y;
    logic                          w_res_push;
    logic                          w_res_full;
    logic [pip_pkg::LOC_WIDTH-1:0] w_res_loc;

    // Front end: vertex bookkeeping and edge classification.
    pip_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_vx      (i_vertex_x[COORD_WIDTH-1:0]),
        .i_vy      (i_vertex_y[COORD_WIDTH-1:0]),
        .i_last    (i_last_vertex),
        .i_job_full(w_job_full),
        .o_full    (full),
        .o_job_push(w_job_push),
        .o_prev_x  (w_prev_x),
        .o_prev_y  (w_prev_y),
        .o_first_x (w_first_x),
        .o_first_y (w_first_y),
        .o_ctl     (w_ctl)
    );

    // Job record: control, query point and the three vertices involved.
    assign w_job_in = {w_ctl,
                       i_query_x[COORD_WIDTH-1:0], i_query_y[COORD_WIDTH-1:0],
                       w_prev_x, w_prev_y,
                       i_vertex_x[COORD_WIDTH-1:0], i_vertex_y[COORD_WIDTH-1:0],
                       w_first_x, w_first_y};

    pip_queue #(
        .WIDTH(JW),
        .DEPTH(JOB_DEPTH)
    ) u_job_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_job_push),
        .i_data (w_job_in),
        .o_full (w_job_full),
        .i_pop  (w_job_pop),
        .o_data (w_job_out),
        .o_empty(w_job_empty)
    );

    assign {w_hd_ctl, w_hd_px, w_hd_py, w_hd_prev_x, w_hd_prev_y,
            w_hd_vx, w_hd_vy, w_hd_first_x, w_hd_first_y} = w_job_out;

    // Back end: edge tests and accumulation.
    pip_back #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_empty(w_job_empty),
        .o_job_pop  (w_job_pop),
        .i_ctl      (w_hd_ctl),
        .i_px       (w_hd_px),
        .i_py       (w_hd_py),
        .i_prev_x   (w_hd_prev_x),
        .i_prev_y   (w_hd_prev_y),
        .i_vx       (w_hd_vx),
        .i_vy       (w_hd_vy),
        .i_first_x  (w_hd_first_x),
        .i_first_y  (w_hd_first_y),
        .i_res_full (w_res_full),
        .o_res_push (w_res_push),
        .o_res_loc  (w_res_loc)
    );

    // Result queue parts the back end from the consumer.
    pip_queue #(
        .WIDTH(pip_pkg::LOC_WIDTH),
        .DEPTH(RES_DEPTH)
    ) u_res_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_res_push),
        .i_data (w_res_loc),
        .o_full (w_res_full),
        .i_pop  (pop),
        .o_data (o_location),
        .o_empty(empty)
    );

endmodule

@@ sv/pip_queue.sv @@
// ----------------------------------------------------------------------------
// Point in polygon test: register queue
// Small first-in first-out queue in flip-flops; DEPTH is a power of two,
// at least two. The head entry is presented combinationally.
// ----------------------------------------------------------------------------
module pip_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW:0]      r_wr_ptr;
    logic [AW:0]      r_rd_ptr;
    logic [AW:0]      n_wr_ptr;
    logic [AW:0]      n_rd_ptr;
    logic             w_wr;
    logic             w_rd;

    // Status from the pointer pair; the extra bit tells full from empty.
    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_full  = (r_wr_ptr[AW] != r_rd_ptr[AW]) &&
                     (r_wr_ptr[AW-1:0] == r_rd_ptr[AW-1:0]);
    assign o_data  = r_mem[r_rd_ptr[AW-1:0]];

    assign w_wr = i_push && !o_full;
    assign w_rd = i_pop && !o_empty;

    // Pointer advance on each transfer.
    always_comb begin
        n_wr_ptr = w_wr ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_rd ? r_rd_ptr + 1'b1 : r_rd_ptr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    // Storage holds payload only and needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr[AW-1:0]] <= i_data;
        end
    end

endmodule

@@ sv/pip_front.sv @@
// ----------------------------------------------------------------------------
// Point in polygon test: front end
// Accepts vertices, keeps the first and previous vertex and the vertex
// count, and classifies which edges of each item the back end must test.
// ----------------------------------------------------------------------------
`include "point_in_polygon_test_defines.svh"

module pip_front #(
    parameter int COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [COORD_WIDTH-1:0] i_vx,
    input  logic [COORD_WIDTH-1:0] i_vy,
    input  logic                   i_last,
    input  logic                   i_job_full,
    output logic                   o_full,
    output logic                   o_job_push,
    output logic [COORD_WIDTH-1:0] o_prev_x,
    output logic [COORD_WIDTH-1:0] o_prev_y,
    output logic [COORD_WIDTH-1:0] o_first_x,
    output logic [COORD_WIDTH-1:0] o_first_y,
    output pip_pkg::t_job_ctl      o_ctl
);

    logic [COORD_WIDTH-1:0] r_first_x;
    logic [COORD_WIDTH-1:0] r_first_y;
    logic [COORD_WIDTH-1:0] r_prev_x;
    logic [COORD_WIDTH-1:0] r_prev_y;
    logic [1:0]             r_count;
    logic [COORD_WIDTH-1:0] n_first_x;
    logic [COORD_WIDTH-1:0] n_first_y;
    logic [COORD_WIDTH-1:0] n_prev_x;
    logic [COORD_WIDTH-1:0] n_prev_y;
    logic [1:0]             n_count;
    logic                   w_accept;

    // An item transfers whenever the job queue has room.
    assign o_full     = i_job_full;
    assign w_accept   = i_push && !i_job_full;
    assign o_job_push = w_accept;

    assign o_prev_x  = r_prev_x;
    assign o_prev_y  = r_prev_y;
    assign o_first_x = r_first_x;
    assign o_first_y = r_first_y;

    // Classify the edges that this vertex brings.
    always_comb begin
        o_ctl.last       = i_last;
        o_ctl.short_poly = i_last && (r_count < 2'd2);
        o_ctl.edge_a     = (r_count != 2'd0);
        o_ctl.edge_b     = i_last && (r_count >= 2'd2);
    end

    // Per-polygon state update on each transfer.
    always_comb begin
        n_first_x = r_first_x;
        n_first_y = r_first_y;
        n_prev_x  = r_prev_x;
        n_prev_y  = r_prev_y;
        n_count   = r_count;
        if (w_accept) begin
            if (r_count == 2'd0) begin
                n_first_x = i_vx;
                n_first_y = i_vy;
            end
            n_prev_x = i_vx;
            n_prev_y = i_vy;
            if (i_last) begin
                n_count = 2'd0;
            end else if (r_count != pip_pkg::COUNT_SAT) begin
                n_count = r_count + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_x <= '0;
            r_first_y <= '0;
            r_prev_x  <= '0;
            r_prev_y  <= '0;
            r_count   <= '0;
        end else begin
            r_first_x <= n_first_x;
            r_first_y <= n_first_y;
            r_prev_x  <= n_prev_x;
            r_prev_y  <= n_prev_y;
            r_count   <= n_count;
        end
    end

    // The closing vertex always starts a fresh polygon.
    `PIP_ASSERT_NEXT(a_count_restart, i_clk, i_rst_n, w_accept && i_last, r_count == 2'd0)

endmodule

@@ sv/pip_edge.sv @@
// ----------------------------------------------------------------------------
// Point in polygon test: edge unit
// Two-stage test of one edge against the query point: coordinate compares
// and differences, then the exact cross products, then the decision.
// ----------------------------------------------------------------------------
module pip_edge #(
    parameter int COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_WIDTH-1:0] i_ax,
    input  logic signed [COORD_WIDTH-1:0] i_ay,
    input  logic signed [COORD_WIDTH-1:0] i_bx,
    input  logic signed [COORD_WIDTH-1:0] i_by,
    input  logic signed [COORD_WIDTH-1:0] i_px,
    input  logic signed [COORD_WIDTH-1:0] i_py,
    output pip_pkg::t_edge_res            o_res
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    logic                 w_by_eq;
    logic                 w_bx_eq;
    logic                 w_ay_eq;
    logic                 w_bx_gt;
    logic                 w_ax_lt;
    logic                 w_straddle;

    logic signed [DW-1:0] r_d1;
    logic signed [DW-1:0] r_d2;
    logic signed [DW-1:0] r_d3;
    logic signed [DW-1:0] r_d4;
    logic                 r_s1_bnd;
    logic                 r_s1_tog;
    logic                 r_s1_cross;
    logic                 r_s1_dir;

    logic signed [PW-1:0] r_p1;
    logic signed [PW-1:0] r_p2;
    logic                 r_s2_bnd;
    logic                 r_s2_tog;
    logic                 r_s2_cross;
    logic                 r_s2_dir;

    // Stage one: compares against the query point.
    assign w_by_eq    = (i_by == i_py);
    assign w_bx_eq    = (i_bx == i_px);
    assign w_ay_eq    = (i_ay == i_py);
    assign w_bx_gt    = (i_bx > i_px);
    assign w_ax_lt    = (i_ax < i_px);
    assign w_straddle = (i_ay < i_py) != (i_by < i_py);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d1       <= DW'(i_ax) - DW'(i_px);
            r_d2       <= DW'(i_by) - DW'(i_py);
            r_d3       <= DW'(i_bx) - DW'(i_px);
            r_d4       <= DW'(i_ay) - DW'(i_py);
            r_s1_bnd   <= w_by_eq && (w_bx_eq || (w_ay_eq && (w_bx_gt == w_ax_lt)));
            r_s1_tog   <= w_straddle && !w_ax_lt && w_bx_gt;
            r_s1_cross <= w_straddle && (w_ax_lt == w_bx_gt);
            r_s1_dir   <= (i_by > i_ay);
        end
    end

    // Stage two: both cross products, exact at full width.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1       <= PW'(r_d1) * PW'(r_d2);
            r_p2       <= PW'(r_d3) * PW'(r_d4);
            r_s2_bnd   <= r_s1_bnd;
            r_s2_tog   <= r_s1_tog;
            r_s2_cross <= r_s1_cross;
            r_s2_dir   <= r_s1_dir;
        end
    end

    // Decision: the direct cases win over the cross product sign.
    always_comb begin
        priority if (r_s2_bnd) begin
            o_res = pip_pkg::EDGE_BOUNDARY;
        end else if (r_s2_tog) begin
            o_res = pip_pkg::EDGE_TOGGLE;
        end else if (r_s2_cross && (r_p1 == r_p2)) begin
            o_res = pip_pkg::EDGE_BOUNDARY;
        end else if (r_s2_cross && ((r_p1 > r_p2) == r_s2_dir)) begin
            o_res = pip_pkg::EDGE_TOGGLE;
        end else begin
            o_res = pip_pkg::EDGE_NONE;
        end
    end

endmodule

@@ sv/pip_back.sv @@
// ----------------------------------------------------------------------------
// Point in polygon test: back end
// Pops jobs, runs the open and closing edges in lock step in u_edge_a
// and u_edge_b, accumulates parity and boundary, and emits results.
// ----------------------------------------------------------------------------
`include "point_in_polygon_test_defines.svh"

module pip_back #(
    parameter int COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_job_empty,
    output logic                             o_job_pop,
    input  pip_pkg::t_job_ctl                i_ctl,
    input  logic [COORD_WIDTH-1:0]           i_px,
    input  logic [COORD_WIDTH-1:0]           i_py,
    input  logic [COORD_WIDTH-1:0]           i_prev_x,
    input  logic [COORD_WIDTH-1:0]           i_prev_y,
    input  logic [COORD_WIDTH-1:0]           i_vx,
    input  logic [COORD_WIDTH-1:0]           i_vy,
    input  logic [COORD_WIDTH-1:0]           i_first_x,
    input  logic [COORD_WIDTH-1:0]           i_first_y,
    input  logic                             i_res_full,
    output logic                             o_res_push,
    output logic [pip_pkg::LOC_WIDTH-1:0]    o_res_loc
);

    logic                 w_en;
    logic                 r_s1_valid;
    logic                 r_s2_valid;
    pip_pkg::t_job_ctl    r_s1_ctl;
    pip_pkg::t_job_ctl    r_s2_ctl;
    logic                 r_parity;
    logic                 r_boundary;
    logic                 n_parity;
    logic                 n_boundary;
    pip_pkg::t_edge_res   w_res_a;
    pip_pkg::t_edge_res   w_res_b;
    logic                 w_hit;
    logic                 w_par;
    pip_pkg::t_location   w_loc;

    // The whole pipeline holds while a finished result cannot transfer.
    assign w_en      = !(r_s2_valid && r_s2_ctl.last && i_res_full);
    assign o_job_pop = w_en && !i_job_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= o_job_pop;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_ctl <= i_ctl;
            r_s2_ctl <= r_s1_ctl;
        end
    end

    // Edge from the previous vertex to the new one.
    pip_edge #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_edge_a (
        .i_clk(i_clk),
        .i_en (w_en),
        .i_ax (i_prev_x),
        .i_ay (i_prev_y),
        .i_bx (i_vx),
        .i_by (i_vy),
        .i_px (i_px),
        .i_py (i_py),
        .o_res(w_res_a)
    );

    // Closing edge from the new vertex back to the first.
    pip_edge #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_edge_b (
        .i_clk(i_clk),
        .i_en (w_en),
        .i_ax (i_vx),
        .i_ay (i_vy),
        .i_bx (i_first_x),
        .i_by (i_first_y),
        .i_px (i_px),
        .i_py (i_py),
        .o_res(w_res_b)
    );

    // Combine both edges with the running state, the open edge first.
    always_comb begin
        w_hit = r_boundary ||
                (r_s2_ctl.edge_a && (w_res_a == pip_pkg::EDGE_BOUNDARY)) ||
                (r_s2_ctl.edge_b && (w_res_b == pip_pkg::EDGE_BOUNDARY));
        w_par = r_parity ^
                (r_s2_ctl.edge_a && (w_res_a == pip_pkg::EDGE_TOGGLE)) ^
                (r_s2_ctl.edge_b && (w_res_b == pip_pkg::EDGE_TOGGLE));
    end

    // Result classification.
    always_comb begin
        priority if (r_s2_ctl.short_poly) begin
            w_loc = pip_pkg::LOC_OUTSIDE;
        end else if (w_hit) begin
            w_loc = pip_pkg::LOC_BOUNDARY;
        end else if (w_par) begin
            w_loc = pip_pkg::LOC_INSIDE;
        end else begin
            w_loc = pip_pkg::LOC_OUTSIDE;
        end
    end

    assign o_res_push = r_s2_valid && r_s2_ctl.last && !i_res_full;
    assign o_res_loc  = w_loc;

    // Running state; the closing vertex clears it for the next polygon.
    always_comb begin
        n_parity   = r_parity;
        n_boundary = r_boundary;
        if (r_s2_valid && w_en) begin
            if (r_s2_ctl.last) begin
                n_parity   = 1'b0;
                n_boundary = 1'b0;
            end else begin
                n_parity   = w_par;
                n_boundary = w_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity   <= 1'b0;
            r_boundary <= 1'b0;
        end else begin
            r_parity   <= n_parity;
            r_boundary <= n_boundary;
        end
    end

    // A stalled job stays in the last stage unchanged.
    `PIP_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_s2_valid && !w_en, r_s2_valid && $stable(r_s2_ctl))
    // A polygon of fewer than three vertices is always reported outside.
    `PIP_ASSERT_IMPL(a_short_outside, i_clk, i_rst_n, o_res_push && r_s2_ctl.short_poly, o_res_loc == pip_pkg::LOC_OUTSIDE)
    // Every emitted result leaves clean per-polygon state behind.
    `PIP_ASSERT_NEXT(a_clear_after_result, i_clk, i_rst_n, o_res_push, !r_parity && !r_boundary)

endmodule

@@ tb/pip_result_checker.sv @@
// ----------------------------------------------------------------------------
// Point in polygon test: result checker
// Watches the vertex and result channels of the block, tracks the polygon
// being received, works out the location each closing vertex must produce,
// and compares every result transfer with the oldest outstanding location.
// ----------------------------------------------------------------------------
module pip_result_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  logic                            i_full,
    input  logic [pip_pkg::FIELD_WIDTH-1:0] i_query_x,
    input  logic [pip_pkg::FIELD_WIDTH-1:0] i_query_y,
    input  logic [pip_pkg::FIELD_WIDTH-1:0] i_vertex_x,
    input  logic [pip_pkg::FIELD_WIDTH-1:0] i_vertex_y,
    input  logic                            i_last_vertex,
    input  logic                            i_empty,
    input  logic                            i_pop,
    input  logic [pip_pkg::LOC_WIDTH-1:0]   i_location,
    output int                              o_errors,
    output int                              o_pending
);

    // Per-polygon state, as the block holds it.
    logic signed [pip_pkg::FIELD_WIDTH-1:0] first_x, first_y;
    logic signed [pip_pkg::FIELD_WIDTH-1:0] prev_x, prev_y;
    logic                                   parity;
    logic                                   on_boundary;
    logic [1:0]                             vertex_count;

    // Locations still owed by the block, oldest first.
    pip_pkg::t_location expected_locs[$];

    // Tests the edge a -> b against the query point p. The cross product is
    // taken at 72 bits so that it is exact for any 32-bit coordinates.
    function automatic pip_pkg::t_edge_res classify_edge(longint ax, longint ay,
                                                         longint bx, longint by,
                                                         longint px, longint py);
        logic signed [71:0] da, db, dc, de, cross_val;
        bit                 need_cross;
        need_cross = 1'b0;
        if (by == py) begin
            if (bx == px || (ay == py && ((bx > px) == (ax < px))))
                return pip_pkg::EDGE_BOUNDARY;
        end
        if ((ay < py) != (by < py)) begin
            if (ax >= px) begin
                if (bx > px)
                    return pip_pkg::EDGE_TOGGLE;
                need_cross = 1'b1;
            end else if (bx > px) begin
                need_cross = 1'b1;
            end
        end
        if (need_cross) begin
            da = ax - px;
            db = by - py;
            dc = bx - px;
            de = ay - py;
            cross_val = da * db - dc * de;
            if (cross_val == 0)
                return pip_pkg::EDGE_BOUNDARY;
            if ((cross_val > 0) == (by > ay))
                return pip_pkg::EDGE_TOGGLE;
        end
        return pip_pkg::EDGE_NONE;
    endfunction

    // Folds one edge outcome into the running parity and boundary flag.
    task automatic fold_edge(pip_pkg::t_edge_res r);
        if (r == pip_pkg::EDGE_BOUNDARY)
            on_boundary = 1'b1;
        else if (r == pip_pkg::EDGE_TOGGLE)
            parity = ~parity;
    endtask

    // Updates the polygon state for one vertex transfer and, on the closing
    // vertex, queues the location the block has to report.
    task automatic take_vertex();
        longint             px, py, vx, vy;
        pip_pkg::t_location loc;
        px = longint'($signed(i_query_x));
        py = longint'($signed(i_query_y));
        vx = longint'($signed(i_vertex_x));
        vy = longint'($signed(i_vertex_y));
        if (vertex_count == 2'd0) begin
            first_x = i_vertex_x;
            first_y = i_vertex_y;
        end else begin
            fold_edge(classify_edge(longint'(prev_x), longint'(prev_y), vx, vy, px, py));
        end
        prev_x = i_vertex_x;
        prev_y = i_vertex_y;
        if (vertex_count < pip_pkg::COUNT_SAT)
            vertex_count = vertex_count + 2'd1;
        if (i_last_vertex) begin
            // Fewer than three vertices never form a polygon.
            if (vertex_count < pip_pkg::COUNT_SAT) begin
                loc = pip_pkg::LOC_OUTSIDE;
            end else begin
                fold_edge(classify_edge(vx, vy, longint'(first_x), longint'(first_y),
                                        px, py));
                if (on_boundary)
                    loc = pip_pkg::LOC_BOUNDARY;
                else
                    loc = parity ? pip_pkg::LOC_INSIDE : pip_pkg::LOC_OUTSIDE;
            end
            expected_locs.insert(expected_locs.size(), loc);
            parity       = 1'b0;
            on_boundary  = 1'b0;
            vertex_count = 2'd0;
        end
    endtask

    // Sample both channels at the clock edge; stimulus changes after it.
    always @(posedge i_clk) begin : track
        pip_pkg::t_location want;
        if (!i_rst_n) begin
            first_x      = '0;
            first_y      = '0;
            prev_x       = '0;
            prev_y       = '0;
            parity       = 1'b0;
            on_boundary  = 1'b0;
            vertex_count = 2'd0;
            expected_locs.delete();
        end else begin
            // A result transfer is always older than any vertex taken now.
            if (i_pop && !i_empty) begin
                if (expected_locs.size() == 0) begin
                    $display("%0t: result transfer with nothing outstanding, got %0d",
                             $time, i_location);
                    o_errors++;
                end else begin
                    want = expected_locs.pop_front();
                    if (i_location !== want) begin
                        $display("%0t: location mismatch, expected %0d, got %0d",
                                 $time, want, i_location);
                        o_errors++;
                    end
                end
            end
            if (i_push && !i_full)
                take_vertex();
        end
        o_pending = expected_locs.size();
    end

endmodule

@@ tb/tb_point_in_polygon_test.sv @@
// ----------------------------------------------------------------------------
// Point in polygon test: testbench top
// Feeds polygons vertex by vertex, first a handful of hand-built shapes and
// then random ones on coarse grids, full-range, extreme and tiny coordinates, with
// bursty pushes and a patterned pop side. A separate checker predicts and
// compares every location; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb_point_in_polygon_test;

    localparam int RANDOM_ITEMS = 1700;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 8;

    // How coordinates of a random polygon are spread.
    typedef enum int {
        SPREAD_GRID,
        SPREAD_FULL,
        SPREAD_EXTREME,
        SPREAD_TINY
    } t_spread;

    // How eagerly the result side pops.
    typedef enum int {
        DRAIN_STEADY,
        DRAIN_HALF,
        DRAIN_SPARSE
    } t_drain;

    typedef struct packed {
        logic [pip_pkg::FIELD_WIDTH-1:0] qx;
        logic [pip_pkg::FIELD_WIDTH-1:0] qy;
        logic [pip_pkg::FIELD_WIDTH-1:0] vx;
        logic [pip_pkg::FIELD_WIDTH-1:0] vy;
        logic                            last;
    } t_vertex_item;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            push          = 1'b0;
    logic                            pop           = 1'b0;
    logic [pip_pkg::FIELD_WIDTH-1:0] query_x       = '0;
    logic [pip_pkg::FIELD_WIDTH-1:0] query_y       = '0;
    logic [pip_pkg::FIELD_WIDTH-1:0] vertex_x      = '0;
    logic [pip_pkg::FIELD_WIDTH-1:0] vertex_y      = '0;
    logic                            last_vertex   = 1'b0;
    logic                            full;
    logic                            empty;
    logic [pip_pkg::LOC_WIDTH-1:0]   location;
    int                              errors;
    int                              pending;

    t_vertex_item                    vertex_feed[$];
    logic [pip_pkg::FIELD_WIDTH-1:0] poly_xs[$];
    logic [pip_pkg::FIELD_WIDTH-1:0] poly_ys[$];
    int                              feed_pos     = 0;
    int                              vertices_in  = 0;
    int                              burst_left   = 1;
    int                              gap_left     = 0;
    t_drain                          drain_mode   = DRAIN_STEADY;
    int                              drain_left   = 0;
    int                              idle_cycles  = 0;

    point_in_polygon_test u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_query_x     (query_x),
        .i_query_y     (query_y),
        .i_vertex_x    (vertex_x),
        .i_vertex_y    (vertex_y),
        .i_last_vertex (last_vertex),
        .empty         (empty),
        .pop           (pop),
        .o_location    (location)
    );

    pip_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_query_x     (query_x),
        .i_query_y     (query_y),
        .i_vertex_x    (vertex_x),
        .i_vertex_y    (vertex_y),
        .i_last_vertex (last_vertex),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_location    (location),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Whole units in Q16.16.
    function automatic logic [pip_pkg::FIELD_WIDTH-1:0] q16(int v);
        return pip_pkg::FIELD_WIDTH'(v * 65536);
    endfunction

    task automatic add_vertex(logic [pip_pkg::FIELD_WIDTH-1:0] qx,
                              logic [pip_pkg::FIELD_WIDTH-1:0] qy,
                              logic [pip_pkg::FIELD_WIDTH-1:0] vx,
                              logic [pip_pkg::FIELD_WIDTH-1:0] vy,
                              logic last);
        t_vertex_item item;
        item.qx   = qx;
        item.qy   = qy;
        item.vx   = vx;
        item.vy   = vy;
        item.last = last;
        vertex_feed.insert(vertex_feed.size(), item);
    endtask

    function automatic t_spread pick_spread();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return SPREAD_GRID;
        if (r < 65)
            return SPREAD_FULL;
        if (r < 80)
            return SPREAD_EXTREME;
        return SPREAD_TINY;
    endfunction

    function automatic logic [pip_pkg::FIELD_WIDTH-1:0] pick_coord(t_spread s);
        unique case (s)
            // Half-unit steps from -4 to 4, so edges and vertices get hit.
            SPREAD_GRID:
                return pip_pkg::FIELD_WIDTH'(($urandom_range(0, 16) - 8) * 32768);
            SPREAD_FULL:    return $urandom();
            SPREAD_EXTREME: begin
                unique case ($urandom_range(0, 6))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    3:       return 32'hFFFF_FFFF;
                    4:       return 32'h0000_0001;
                    5:       return 32'h8000_0001;
                    default: return 32'h7FFF_FFFE;
                endcase
            end
            default:        return pip_pkg::FIELD_WIDTH'($urandom_range(0, 6) - 3);
        endcase
    endfunction

    // Query point for the current polygon: often on a vertex, an edge
    // midpoint or the height of a vertex, otherwise anywhere.
    task automatic pick_query(t_spread s, output logic [pip_pkg::FIELD_WIDTH-1:0] qx,
                              output logic [pip_pkg::FIELD_WIDTH-1:0] qy);
        int unsigned      r;
        int               k;
        logic signed [32:0] sum;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, poly_xs.size() - 1);
        qx = pick_coord(s);
        qy = pick_coord(s);
        if (r < 25) begin
            qx = poly_xs[k];
            qy = poly_ys[k];
        end else if (r < 40) begin
            sum = $signed(poly_xs[k]) + $signed(poly_xs[(k + 1) % poly_xs.size()]);
            qx  = sum[32:1];
            sum = $signed(poly_ys[k]) + $signed(poly_ys[(k + 1) % poly_ys.size()]);
            qy  = sum[32:1];
        end else if (r < 55) begin
            qy = poly_ys[k];
        end
    endtask

    // One random polygon, mostly well formed, with a few too short to count.
    task automatic add_random_polygon();
        int unsigned                     r;
        int                              n;
        t_spread                         s;
        bit                              wander;
        logic [pip_pkg::FIELD_WIDTH-1:0] qx, qy;
        r = $urandom_range(0, 99);
        if (r < 6)
            n = 1;
        else if (r < 12)
            n = 2;
        else if (r < 88)
            n = $urandom_range(3, 6);
        else
            n = $urandom_range(7, 14);
        s = pick_spread();
        poly_xs.delete();
        poly_ys.delete();
        for (int i = 0; i < n; i++) begin
            poly_xs.insert(poly_xs.size(),
                           ($urandom_range(0, 9) == 0) ? pick_coord(pick_spread())
                                                       : pick_coord(s));
            poly_ys.insert(poly_ys.size(),
                           ($urandom_range(0, 9) == 0) ? pick_coord(pick_spread())
                                                       : pick_coord(s));
        end
        wander = ($urandom_range(0, 9) == 0);
        pick_query(s, qx, qy);
        for (int i = 0; i < n; i++) begin
            if (wander && i > 0)
                pick_query(s, qx, qy);
            add_vertex(qx, qy, poly_xs[i], poly_ys[i], i == n - 1);
        end
    endtask

    // Vertex side: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full)
                vertices_in <= vertices_in + 1;
            if (!push || !full) begin
                if (gap_left > 0) begin
                    gap_left--;
                    push <= 1'b0;
                end else if (feed_pos < vertex_feed.size()) begin
                    query_x     <= vertex_feed[feed_pos].qx;
                    query_y     <= vertex_feed[feed_pos].qy;
                    vertex_x    <= vertex_feed[feed_pos].vx;
                    vertex_y    <= vertex_feed[feed_pos].vy;
                    last_vertex <= vertex_feed[feed_pos].last;
                    push        <= 1'b1;
                    feed_pos++;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Result side: pops in phases of steady, half-rate and sparse draining.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (drain_left == 0) begin
                drain_mode = t_drain'($urandom_range(0, 2));
                drain_left = $urandom_range(20, 120);
            end
            drain_left--;
            unique case (drain_mode)
                DRAIN_STEADY: pop <= 1'b1;
                DRAIN_HALF:   pop <= ($urandom_range(0, 1) == 1);
                default:      pop <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_point_in_polygon_test: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        // Single vertex sitting on the query point: still outside.
        add_vertex(q16(1), q16(1), q16(1), q16(1), 1'b1);
        // Two vertices with the query point on the segment: outside.
        add_vertex(q16(1), q16(0), q16(0), q16(0), 1'b0);
        add_vertex(q16(1), q16(0), q16(2), q16(0), 1'b1);
        // Square with the point in its middle.
        add_vertex(q16(2), q16(2), q16(0), q16(0), 1'b0);
        add_vertex(q16(2), q16(2), q16(4), q16(0), 1'b0);
        add_vertex(q16(2), q16(2), q16(4), q16(4), 1'b0);
        add_vertex(q16(2), q16(2), q16(0), q16(4), 1'b1);
        // Triangle with the point beyond its hypotenuse.
        add_vertex(q16(3), q16(3), q16(0), q16(0), 1'b0);
        add_vertex(q16(3), q16(3), q16(4), q16(0), 1'b0);
        add_vertex(q16(3), q16(3), q16(0), q16(4), 1'b1);
        // Query point on a vertex.
        add_vertex(q16(0), q16(4), q16(0), q16(0), 1'b0);
        add_vertex(q16(0), q16(4), q16(4), q16(0), 1'b0);
        add_vertex(q16(0), q16(4), q16(0), q16(4), 1'b1);
        // Triangle spanning the whole coordinate range.
        add_vertex(32'hFFFF_FFFF, 32'h8000_0001, 32'h8000_0000, 32'h8000_0000, 1'b0);
        add_vertex(32'hFFFF_FFFF, 32'h8000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        add_vertex(32'hFFFF_FFFF, 32'h8000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        // Query point changing with every vertex.
        add_vertex(q16(1), q16(1), q16(0), q16(0), 1'b0);
        add_vertex(q16(5), q16(5), q16(4), q16(0), 1'b0);
        add_vertex(q16(-1), q16(2), q16(0), q16(4), 1'b1);
        // Query point on a horizontal edge.
        add_vertex(q16(2), q16(0), q16(0), q16(0), 1'b0);
        add_vertex(q16(2), q16(0), q16(4), q16(0), 1'b0);
        add_vertex(q16(2), q16(0), q16(2), q16(4), 1'b1);

        begin : build_random
            int directed_count;
            directed_count = vertex_feed.size();
            while (vertex_feed.size() < directed_count + RANDOM_ITEMS)
                add_random_polygon();
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every vertex to go in and every location to come out.
        do @(negedge i_clk); while (vertices_in != vertex_feed.size());
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (errors == 0)
            $display("tb_point_in_polygon_test: done, clean");
        else
            $display("tb_point_in_polygon_test: done, errors");
        $finish;
    end

endmodule
